>>> design/mandelbrot_escape_time_pixel_unit_defines.svh
// assertion helpers shared by the checker
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_DEFINES_SVH

// same-cycle implication
`define MBROT_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("mbrot same-cycle check failed");

// next-cycle implication
`define MBROT_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("mbrot next-cycle check failed");

`endif

>>> design/mbrot_pkg.sv
package mbrot_pkg;

   localparam int DATA_W      = 64;
   localparam int STEP_W      = 63;
   localparam int ITER_W      = 16;
   localparam int OFFSET_W    = 14;
   localparam int GRAY_W      = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int HALF_W      = DATA_W / 2;

   localparam int DEF_MAX_RESOLUTION = 8192;
   localparam int DEF_FRAC_BITS      = 56;
   localparam int DEF_COUNT_WIDTH    = 16;

   localparam logic [ITER_W-1:0] MAX_ITER_RESET = ITER_W'(100);

   localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CENTER_RE        = 3'd0,
      CSR_CENTER_IM        = 3'd1,
      CSR_PIXEL_STEP       = 3'd2,
      CSR_MAX_ITERATIONS   = 3'd3,
      CSR_ESCAPE_THRESHOLD = 3'd4
   } mbrot_csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CR,
      ST_CI,
      ST_Y2,
      ST_XM,
      ST_QT,
      ST_LHS,
      ST_CARD,
      ST_ITER,
      ST_RI,
      ST_ZUPD1,
      ST_ZUPD2,
      ST_RR,
      ST_II,
      ST_MAG,
      ST_GRAY,
      ST_DIV,
      ST_RSP
   } mbrot_state_type;

   // operand pair of the shared multiplier, also picks where the product lands
   typedef enum logic [2:0] {
      MUL_OFFR_STEP,
      MUL_OFFI_STEP,
      MUL_CI_CI,
      MUL_XM_XM,
      MUL_Q_T,
      MUL_ZR_ZI,
      MUL_ZR_ZR,
      MUL_ZI_ZI
   } mbrot_mul_sel_type;

   typedef enum logic [2:0] {
      ALU_NONE,
      ALU_Q_T,
      ALU_ZINIT,
      ALU_ZUPD1,
      ALU_ZUPD2,
      ALU_CARD_SET,
      ALU_COUNT_INC,
      ALU_GRAY_ZERO
   } mbrot_alu_op_type;

   typedef struct packed {
      logic              load;
      logic              mul_go;
      mbrot_mul_sel_type mul_sel;
      mbrot_alu_op_type  alu_op;
      logic              div_go;
   } mbrot_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic in_card;
      logic escape;
      logic count_lt_max;
      logic max_zero;
   } mbrot_status_type;

endpackage

>>> design/mbrot_mul.sv
module mbrot_mul import mbrot_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     go,
   input  logic                     frac_shift,
   input  logic signed [DATA_W-1:0] a,
   input  logic signed [DATA_W-1:0] b,
   output logic                     done,
   output logic signed [DATA_W-1:0] result
);

   localparam logic [2:0] PH_LAST = 3'd5;

   logic                     busy_ff;
   logic                     done_ff;
   logic [2:0]               ph_ff;
   logic [DATA_W-1:0]        am_ff;
   logic [DATA_W-1:0]        bm_ff;
   logic                     neg_ff;
   logic                     frac_ff;
   logic [DATA_W-1:0]        prod_ff;
   logic [1:0]               pw_ff;
   logic [PROD_W-1:0]        acc_ff;
   logic signed [DATA_W-1:0] result_ff;

   logic [HALF_W-1:0]        a_part;
   logic [HALF_W-1:0]        b_part;
   logic [DATA_W-1:0]        pp;
   logic [PROD_W-1:0]        addend;
   logic [DATA_W-1:0]        r;
   logic                     over;
   logic                     rem;
   logic signed [DATA_W-1:0] result_in;

   // partial products a0b0, a0b1, a1b0, a1b1 in phases 0 to 3
   assign a_part = ph_ff[1] ? am_ff[DATA_W-1:HALF_W] : am_ff[HALF_W-1:0];
   assign b_part = ph_ff[0] ? bm_ff[DATA_W-1:HALF_W] : bm_ff[HALF_W-1:0];
   assign pp     = a_part * b_part;

   always_comb begin
      unique case (pw_ff)
         2'd0:    addend = {{DATA_W{1'b0}}, prod_ff};
         2'd1:    addend = {{HALF_W{1'b0}}, prod_ff, {HALF_W{1'b0}}};
         2'd2:    addend = {prod_ff, {DATA_W{1'b0}}};
         default: addend = '0;
      endcase
   end

   // floor shift and saturate; -(r+1) is ~r when the dropped bits are nonzero
   always_comb begin
      if (frac_ff) begin
         over = |acc_ff[PROD_W-1:DATA_W+FRAC_BITS];
         r    = acc_ff[FRAC_BITS+DATA_W-1:FRAC_BITS];
         rem  = |acc_ff[FRAC_BITS-1:0];
      end else begin
         over = |acc_ff[PROD_W-1:DATA_W];
         r    = acc_ff[DATA_W-1:0];
         rem  = 1'b0;
      end
      if (neg_ff) begin
         if (over) begin
            result_in = SAT_MIN;
         end else if (rem) begin
            result_in = (r[DATA_W-1] | (&r[DATA_W-2:0])) ? SAT_MIN : $signed(~r);
         end else begin
            result_in = r[DATA_W-1] ? SAT_MIN : $signed(-r);
         end
      end else begin
         result_in = (over | r[DATA_W-1]) ? SAT_MAX : $signed(r);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         ph_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (!busy_ff) begin
            if (go && !done_ff) begin
               busy_ff <= 1'b1;
               ph_ff   <= '0;
            end
         end else begin
            ph_ff <= ph_ff + 3'd1;
            if (ph_ff == PH_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!busy_ff && go && !done_ff) begin
         am_ff   <= a[DATA_W-1] ? -a : a;
         bm_ff   <= b[DATA_W-1] ? -b : b;
         neg_ff  <= a[DATA_W-1] ^ b[DATA_W-1];
         frac_ff <= frac_shift;
         acc_ff  <= '0;
      end else if (busy_ff) begin
         if (ph_ff < 3'd4) begin
            prod_ff <= pp;
            pw_ff   <= 2'({1'b0, ph_ff[1]} + {1'b0, ph_ff[0]});
         end
         if (ph_ff != 3'd0 && ph_ff != PH_LAST) begin
            acc_ff <= acc_ff + addend;
         end
         if (ph_ff == PH_LAST) begin
            result_ff <= result_in;
         end
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

>>> design/mbrot_div.sv
module mbrot_div import mbrot_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     go,
   input  logic [ITER_W+GRAY_W-1:0] dividend,
   input  logic [ITER_W-1:0]        divisor,
   output logic                     done,
   output logic [GRAY_W-1:0]        quotient
);

   localparam int STEP_CNT_W = $clog2(GRAY_W);
   localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(GRAY_W - 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [STEP_CNT_W-1:0] step_ff;
   logic [ITER_W-1:0]     rem_ff;
   logic [GRAY_W-1:0]     low_ff;
   logic [GRAY_W-1:0]     quo_ff;

   logic [ITER_W:0]       trial;
   logic                  fit;

   // quotient fits 8 bits since count never exceeds the limit
   assign trial = {rem_ff, low_ff[GRAY_W-1]};
   assign fit   = trial >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (!busy_ff) begin
            if (go && !done_ff) begin
               busy_ff <= 1'b1;
            end
         end else if (step_ff == STEP_LAST) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!busy_ff) begin
         if (go && !done_ff) begin
            rem_ff  <= dividend[ITER_W+GRAY_W-1:GRAY_W];
            low_ff  <= dividend[GRAY_W-1:0];
            quo_ff  <= '0;
            step_ff <= '0;
         end
      end else begin
         rem_ff  <= fit ? ITER_W'(trial - {1'b0, divisor}) : trial[ITER_W-1:0];
         low_ff  <= {low_ff[GRAY_W-2:0], 1'b0};
         quo_ff  <= {quo_ff[GRAY_W-2:0], fit};
         step_ff <= step_ff + STEP_CNT_W'(1);
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> design/mbrot_datapath.sv
module mbrot_datapath import mbrot_pkg::*; #(
   parameter int MAX_RESOLUTION = DEF_MAX_RESOLUTION,
   parameter int FRAC_BITS      = DEF_FRAC_BITS,
   parameter int COUNT_WIDTH    = DEF_COUNT_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]          csr_write_data,
   input  logic signed [OFFSET_W-1:0] req_col_offset,
   input  logic signed [OFFSET_W-1:0] req_row_offset,
   input  mbrot_cmd_type              cmd,
   output mbrot_status_type           status,
   output logic [COUNT_WIDTH-1:0]     iteration_count,
   output logic [GRAY_W-1:0]          gray_level
);

   localparam int RES_BITS = $clog2(MAX_RESOLUTION);
   localparam int CMP_W    = ((OFFSET_W > RES_BITS + 1) ? OFFSET_W : RES_BITS + 1) + 1;
   localparam logic signed [CMP_W-1:0] HALF_RES     = CMP_W'(MAX_RESOLUTION / 2);
   localparam logic signed [CMP_W-1:0] NEG_HALF_RES = -HALF_RES;

   localparam logic signed [DATA_W-1:0] QUARTER = DATA_W'(64'd1 << (FRAC_BITS - 2));
   localparam logic [STEP_W-1:0] STEP_RESET =
      STEP_W'(((64'd3 << FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic [DATA_W-1:0] TEN_FIX  = 64'd10 << FRAC_BITS;
   localparam logic [DATA_W-1:0] STEP_TOP = {1'b0, {STEP_W{1'b1}}};
   localparam logic [STEP_W-1:0] THR_RESET =
      (TEN_FIX > STEP_TOP) ? {STEP_W{1'b1}} : TEN_FIX[STEP_W-1:0];

   function automatic logic signed [DATA_W-1:0] sat_add(
      input logic signed [DATA_W-1:0] x,
      input logic signed [DATA_W-1:0] y
   );
      logic signed [DATA_W:0] s;
      s = {x[DATA_W-1], x} + {y[DATA_W-1], y};
      if (s[DATA_W] != s[DATA_W-1]) begin
         sat_add = s[DATA_W] ? SAT_MIN : SAT_MAX;
      end else begin
         sat_add = s[DATA_W-1:0];
      end
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_sub(
      input logic signed [DATA_W-1:0] x,
      input logic signed [DATA_W-1:0] y
   );
      logic signed [DATA_W:0] s;
      s = {x[DATA_W-1], x} - {y[DATA_W-1], y};
      if (s[DATA_W] != s[DATA_W-1]) begin
         sat_sub = s[DATA_W] ? SAT_MIN : SAT_MAX;
      end else begin
         sat_sub = s[DATA_W-1:0];
      end
   endfunction

   function automatic logic signed [CMP_W-1:0] clamp_offset(
      input logic signed [OFFSET_W-1:0] raw
   );
      logic signed [CMP_W-1:0] v;
      v = CMP_W'(raw);
      if (v > HALF_RES) begin
         v = HALF_RES;
      end else if (v < NEG_HALF_RES) begin
         v = NEG_HALF_RES;
      end
      clamp_offset = v;
   endfunction

   logic signed [DATA_W-1:0] center_re_ff;
   logic signed [DATA_W-1:0] center_im_ff;
   logic [STEP_W-1:0]        step_ff;
   logic [ITER_W-1:0]        max_ff;
   logic [STEP_W-1:0]        thr_ff;

   logic signed [CMP_W-1:0]  offr_ff;
   logic signed [CMP_W-1:0]  offi_ff;
   logic signed [DATA_W-1:0] cr_ff;
   logic signed [DATA_W-1:0] ci_ff;
   logic signed [DATA_W-1:0] xm_ff;
   logic signed [DATA_W-1:0] y2_ff;
   logic signed [DATA_W-1:0] q_ff;
   logic signed [DATA_W-1:0] tr_ff;
   logic signed [DATA_W-1:0] ti_ff;
   logic signed [DATA_W-1:0] zr_ff;
   logic signed [DATA_W-1:0] zi_ff;
   logic signed [DATA_W-1:0] rr_ff;
   logic signed [DATA_W-1:0] ii_ff;
   logic signed [DATA_W-1:0] ri_ff;
   logic                     in_card_ff;
   logic [ITER_W-1:0]        count_ff;
   logic [GRAY_W-1:0]        gray_ff;

   logic signed [DATA_W-1:0] mul_a;
   logic signed [DATA_W-1:0] mul_b;
   logic                     mul_frac;
   logic                     mul_done;
   logic signed [DATA_W-1:0] mul_res;
   logic                     div_done;
   logic [GRAY_W-1:0]        div_q;
   logic [ITER_W+GRAY_W-1:0] dividend;
   logic signed [DATA_W-1:0] mag;
   logic signed [DATA_W-1:0] rhs;
   logic signed [DATA_W-1:0] step_s;
   logic [ITER_W+COUNT_WIDTH-1:0] count_wide;

   assign step_s = $signed({1'b0, step_ff});
   assign rhs    = $signed({2'b00, y2_ff[DATA_W-1:2]});

   always_comb begin
      mul_frac = 1'b1;
      unique case (cmd.mul_sel)
         MUL_OFFR_STEP: begin
            mul_a    = DATA_W'(offr_ff);
            mul_b    = step_s;
            mul_frac = 1'b0;
         end
         MUL_OFFI_STEP: begin
            mul_a    = DATA_W'(offi_ff);
            mul_b    = step_s;
            mul_frac = 1'b0;
         end
         MUL_CI_CI: begin
            mul_a = ci_ff;
            mul_b = ci_ff;
         end
         MUL_XM_XM: begin
            mul_a = xm_ff;
            mul_b = xm_ff;
         end
         MUL_Q_T: begin
            mul_a = q_ff;
            mul_b = tr_ff;
         end
         MUL_ZR_ZI: begin
            mul_a = zr_ff;
            mul_b = zi_ff;
         end
         MUL_ZR_ZR: begin
            mul_a = zr_ff;
            mul_b = zr_ff;
         end
         MUL_ZI_ZI: begin
            mul_a = zi_ff;
            mul_b = zi_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   mbrot_mul #(
      .FRAC_BITS(FRAC_BITS)
   ) u_mul (
      .clock     (clock),
      .reset     (reset),
      .go        (cmd.mul_go),
      .frac_shift(mul_frac),
      .a         (mul_a),
      .b         (mul_b),
      .done      (mul_done),
      .result    (mul_res)
   );

   // 255 * count as a shift and subtract
   assign dividend = {count_ff, {GRAY_W{1'b0}}} - {{GRAY_W{1'b0}}, count_ff};

   mbrot_div u_div (
      .clock   (clock),
      .reset   (reset),
      .go      (cmd.div_go),
      .dividend(dividend),
      .divisor (max_ff),
      .done    (div_done),
      .quotient(div_q)
   );

   assign mag = sat_add(rr_ff, ii_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         center_re_ff <= '0;
         center_im_ff <= '0;
         step_ff      <= STEP_RESET;
         max_ff       <= MAX_ITER_RESET;
         thr_ff       <= THR_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CENTER_RE:        center_re_ff <= csr_write_data;
            CSR_CENTER_IM:        center_im_ff <= csr_write_data;
            CSR_PIXEL_STEP:       step_ff      <= csr_write_data[STEP_W-1:0];
            CSR_MAX_ITERATIONS:   max_ff       <= csr_write_data[ITER_W-1:0];
            CSR_ESCAPE_THRESHOLD: thr_ff       <= csr_write_data[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         offr_ff <= clamp_offset(req_col_offset);
         offi_ff <= clamp_offset(req_row_offset);
      end
      if (mul_done) begin
         unique case (cmd.mul_sel)
            MUL_OFFR_STEP: cr_ff <= sat_add(center_re_ff, mul_res);
            MUL_OFFI_STEP: begin
               ci_ff <= sat_add(center_im_ff, mul_res);
               xm_ff <= sat_sub(cr_ff, QUARTER);
            end
            MUL_CI_CI:     y2_ff      <= mul_res;
            MUL_XM_XM:     q_ff       <= sat_add(mul_res, y2_ff);
            MUL_Q_T:       in_card_ff <= mul_res <= rhs;
            MUL_ZR_ZI:     ri_ff      <= mul_res;
            MUL_ZR_ZR:     rr_ff      <= mul_res;
            MUL_ZI_ZI:     ii_ff      <= mul_res;
            default: ;
         endcase
      end
      unique case (cmd.alu_op)
         ALU_NONE: ;
         ALU_Q_T: tr_ff <= sat_add(q_ff, xm_ff);
         ALU_ZINIT: begin
            zr_ff    <= '0;
            zi_ff    <= '0;
            rr_ff    <= '0;
            ii_ff    <= '0;
            count_ff <= '0;
         end
         ALU_ZUPD1: begin
            tr_ff <= sat_sub(rr_ff, ii_ff);
            ti_ff <= sat_add(ri_ff, ri_ff);
         end
         ALU_ZUPD2: begin
            zr_ff <= sat_add(tr_ff, cr_ff);
            zi_ff <= sat_add(ti_ff, ci_ff);
         end
         ALU_CARD_SET:  count_ff <= max_ff;
         ALU_COUNT_INC: count_ff <= count_ff + ITER_W'(1);
         ALU_GRAY_ZERO: gray_ff  <= '0;
         default: ;
      endcase
      if (div_done) begin
         gray_ff <= div_q;
      end
   end

   always_comb begin
      status.mul_done     = mul_done;
      status.div_done     = div_done;
      status.in_card      = in_card_ff;
      status.escape       = $unsigned(mag) > {1'b0, thr_ff};
      status.count_lt_max = count_ff < max_ff;
      status.max_zero     = max_ff == '0;
   end

   assign count_wide      = {{COUNT_WIDTH{1'b0}}, count_ff};
   assign iteration_count = count_wide[COUNT_WIDTH-1:0];
   assign gray_level      = gray_ff;

endmodule

>>> design/mbrot_ctrl.sv
module mbrot_ctrl import mbrot_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  mbrot_status_type status,
   output logic             busy,
   output logic             rsp_valid,
   output mbrot_cmd_type    cmd
);

   mbrot_state_type state_ff;
   mbrot_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      busy        = 1'b1;
      rsp_valid   = 1'b0;
      cmd.load    = 1'b0;
      cmd.mul_go  = 1'b0;
      cmd.mul_sel = MUL_OFFR_STEP;
      cmd.alu_op  = ALU_NONE;
      cmd.div_go  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CR;
            end
         end
         ST_CR: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_OFFR_STEP;
            if (status.mul_done) state_in = ST_CI;
         end
         ST_CI: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_OFFI_STEP;
            if (status.mul_done) state_in = ST_Y2;
         end
         ST_Y2: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_CI_CI;
            if (status.mul_done) state_in = ST_XM;
         end
         ST_XM: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_XM_XM;
            if (status.mul_done) state_in = ST_QT;
         end
         ST_QT: begin
            cmd.alu_op = ALU_Q_T;
            state_in   = ST_LHS;
         end
         ST_LHS: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_Q_T;
            if (status.mul_done) state_in = ST_CARD;
         end
         ST_CARD: begin
            if (status.in_card) begin
               cmd.alu_op = ALU_CARD_SET;
               state_in   = ST_GRAY;
            end else begin
               cmd.alu_op = ALU_ZINIT;
               state_in   = ST_ITER;
            end
         end
         ST_ITER: begin
            state_in = status.count_lt_max ? ST_RI : ST_GRAY;
         end
         ST_RI: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_ZR_ZI;
            if (status.mul_done) state_in = ST_ZUPD1;
         end
         ST_ZUPD1: begin
            cmd.alu_op = ALU_ZUPD1;
            state_in   = ST_ZUPD2;
         end
         ST_ZUPD2: begin
            cmd.alu_op = ALU_ZUPD2;
            state_in   = ST_RR;
         end
         ST_RR: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_ZR_ZR;
            if (status.mul_done) state_in = ST_II;
         end
         ST_II: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_ZI_ZI;
            if (status.mul_done) state_in = ST_MAG;
         end
         ST_MAG: begin
            // squares of the new z double as the next pass's rr and ii
            if (status.escape) begin
               state_in = ST_GRAY;
            end else begin
               cmd.alu_op = ALU_COUNT_INC;
               state_in   = ST_ITER;
            end
         end
         ST_GRAY: begin
            if (status.max_zero) begin
               cmd.alu_op = ALU_GRAY_ZERO;
               state_in   = ST_RSP;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_go = 1'b1;
            if (status.div_done) state_in = ST_RSP;
         end
         ST_RSP: begin
            busy      = 1'b0;
            rsp_valid = 1'b1;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> design/mandelbrot_escape_time_pixel_unit.sv
// channel  | ports                                        | transfer
// request  | start, busy, req_col_offset, req_row_offset  | start high while busy low
// result   | rsp_valid, rsp_iteration_count, rsp_gray_level | one-cycle strobe, no back-pressure
// config   | csr_write_en, csr_index, csr_write_data      | write on each enabled edge
//
// one request at a time; a point inside the main cardioid skips the escape loop; all
// products come from one shared 32x32 multiplier that builds each 64-bit product
// from 32-bit halves, three products per loop pass; a zero limit skips the divide.
// a new request is taken in the strobe cycle; synchronous reset returns to idle with
// default view settings. the receiver cannot stall, so each result shows once.
module mandelbrot_escape_time_pixel_unit import mbrot_pkg::*; #(
   parameter int MAX_RESOLUTION = DEF_MAX_RESOLUTION,
   parameter int FRAC_BITS      = DEF_FRAC_BITS,
   parameter int COUNT_WIDTH    = DEF_COUNT_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [OFFSET_W-1:0] req_col_offset,
   input  logic signed [OFFSET_W-1:0] req_row_offset,
   output logic                       rsp_valid,
   output logic [COUNT_WIDTH-1:0]     rsp_iteration_count,
   output logic [GRAY_W-1:0]          rsp_gray_level,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]          csr_write_data
);

   mbrot_cmd_type    cmd;
   mbrot_status_type status;

   mbrot_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .status   (status),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .cmd      (cmd)
   );

   mbrot_datapath #(
      .MAX_RESOLUTION(MAX_RESOLUTION),
      .FRAC_BITS     (FRAC_BITS),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_col_offset (req_col_offset),
      .req_row_offset (req_row_offset),
      .cmd            (cmd),
      .status         (status),
      .iteration_count(rsp_iteration_count),
      .gray_level     (rsp_gray_level)
   );

endmodule

>>> design/mbrot_checker.sv
`include "mandelbrot_escape_time_pixel_unit_defines.svh"

module mbrot_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // a request never finishes in the cycle after another result
   `MBROT_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)
   // the strobe cycle can take the next request
   `MBROT_ASSERT_SAME(a_strobe_not_busy, clock, reset, rsp_valid, !busy)
   `MBROT_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // work only ends by showing a result
   `MBROT_ASSERT_SAME(a_end_strobe, clock, reset, $fell(busy), rsp_valid)

endmodule

bind mandelbrot_escape_time_pixel_unit mbrot_checker u_mbrot_checker (.*);

>>> tb/sv/mandelbrot_escape_time_pixel_unit_checker.sv
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_unit_checker import mbrot_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic signed [OFFSET_W-1:0] req_col_offset,
   input  logic signed [OFFSET_W-1:0] req_row_offset,
   input  logic                       rsp_valid,
   input  logic [ITER_W-1:0]          rsp_iteration_count,
   input  logic [GRAY_W-1:0]          rsp_gray_level,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]          csr_write_data,
   output int                         mismatch_count,
   output int                         pending_count
);

   localparam int FRAC     = DEF_FRAC_BITS;
   localparam int HALF_RES = DEF_MAX_RESOLUTION / 2;

   typedef logic signed [DATA_W-1:0] fix_t;

   typedef struct packed {
      logic [ITER_W-1:0] count;
      logic [GRAY_W-1:0] gray;
   } pixel_t;

   fix_t              view_re;
   fix_t              view_im;
   logic [STEP_W-1:0] view_step;
   logic [ITER_W-1:0] iter_limit;
   logic [STEP_W-1:0] escape_bound;
   pixel_t            expected_pixels[$];

   function automatic fix_t clip64(input logic signed [PROD_W-1:0] v);
      if (&v[PROD_W-1:DATA_W-1] || ~|v[PROD_W-1:DATA_W-1]) return v[DATA_W-1:0];
      return v[PROD_W-1] ? SAT_MIN : SAT_MAX;
   endfunction

   // exact product, floor shift, saturate
   function automatic fix_t fix_mul(input fix_t a, input fix_t b, input int sh);
      logic signed [PROD_W-1:0] wa;
      logic signed [PROD_W-1:0] wb;
      wa = a;
      wb = b;
      return clip64((wa * wb) >>> sh);
   endfunction

   function automatic fix_t fix_add(input fix_t a, input fix_t b);
      logic signed [DATA_W:0] s;
      s = a + b;
      if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? SAT_MIN : SAT_MAX;
      return s[DATA_W-1:0];
   endfunction

   function automatic fix_t fix_sub(input fix_t a, input fix_t b);
      logic signed [DATA_W:0] s;
      s = a - b;
      if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? SAT_MIN : SAT_MAX;
      return s[DATA_W-1:0];
   endfunction

   function automatic fix_t pixel_coord(input fix_t center, input logic signed [OFFSET_W-1:0] raw);
      int   v;
      fix_t step;
      v = raw;
      if (v > HALF_RES) v = HALF_RES;
      if (v < -HALF_RES) v = -HALF_RES;
      step = {1'b0, view_step};
      return fix_add(center, fix_mul(fix_t'(v), step, 0));
   endfunction

   // q*(q + (x - 1/4)) <= y^2/4
   function automatic logic in_main_cardioid(input fix_t x, input fix_t y);
      fix_t xm;
      fix_t y2;
      fix_t q;
      fix_t lhs;
      xm  = fix_sub(x, fix_t'(64'd1 << (FRAC - 2)));
      y2  = fix_mul(y, y, FRAC);
      q   = fix_add(fix_mul(xm, xm, FRAC), y2);
      lhs = fix_mul(q, fix_add(q, xm), FRAC);
      return lhs <= fix_t'({2'b00, y2[DATA_W-1:2]});
   endfunction

   function automatic pixel_t escape_pixel(input logic signed [OFFSET_W-1:0] col,
                                           input logic signed [OFFSET_W-1:0] row);
      fix_t        cr;
      fix_t        ci;
      fix_t        zr;
      fix_t        zi;
      fix_t        rr;
      fix_t        ii;
      fix_t        ri;
      fix_t        mag;
      int unsigned n;
      pixel_t      p;
      cr = pixel_coord(view_re, col);
      ci = pixel_coord(view_im, row);
      n  = 0;
      if (in_main_cardioid(cr, ci)) begin
         n = iter_limit;
      end else begin
         zr = '0;
         zi = '0;
         while (n < iter_limit) begin
            rr  = fix_mul(zr, zr, FRAC);
            ii  = fix_mul(zi, zi, FRAC);
            ri  = fix_mul(zr, zi, FRAC);
            zr  = fix_add(fix_sub(rr, ii), cr);
            zi  = fix_add(fix_add(ri, ri), ci);
            mag = fix_add(fix_mul(zr, zr, FRAC), fix_mul(zi, zi, FRAC));
            if ($unsigned(mag) > {1'b0, escape_bound}) break;
            n++;
         end
      end
      p.count = ITER_W'(n);
      p.gray  = (iter_limit != 0) ? GRAY_W'((255 * n) / iter_limit) : '0;
      return p;
   endfunction

   always @(posedge clock) begin
      pixel_t got;
      pixel_t want;
      int     errs;
      errs = 0;
      if (reset) begin
         view_re        <= '0;
         view_im        <= '0;
         view_step      <= STEP_W'(((64'd3 << FRAC) + 64'd500) / 64'd1000);
         iter_limit     <= MAX_ITER_RESET;
         escape_bound   <= STEP_W'(64'd10 << FRAC);
         mismatch_count <= 0;
         pending_count  <= 0;
         expected_pixels.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_CENTER_RE:        view_re      <= csr_write_data;
               CSR_CENTER_IM:        view_im      <= csr_write_data;
               CSR_PIXEL_STEP:       view_step    <= csr_write_data[STEP_W-1:0];
               CSR_MAX_ITERATIONS:   iter_limit   <= csr_write_data[ITER_W-1:0];
               CSR_ESCAPE_THRESHOLD: escape_bound <= csr_write_data[STEP_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            got.count = rsp_iteration_count;
            got.gray  = rsp_gray_level;
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected result, count %0d gray %0d", $time,
                        got.count, got.gray);
               errs++;
            end else begin
               want = expected_pixels.pop_front();
               if (got.count !== want.count) begin
                  $display("%0t: iteration_count expected %0d got %0d", $time,
                           want.count, got.count);
                  errs++;
               end
               if (got.gray !== want.gray) begin
                  $display("%0t: gray_level expected %0d got %0d", $time,
                           want.gray, got.gray);
                  errs++;
               end
            end
         end
         if (start && !busy)
            expected_pixels.push_back(escape_pixel(req_col_offset, req_row_offset));
         mismatch_count <= mismatch_count + errs;
         pending_count  <= expected_pixels.size();
      end
   end

endmodule

>>> tb/sv/mandelbrot_escape_time_pixel_unit_test.sv
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_unit_test;
   import mbrot_pkg::*;

   localparam logic signed [DATA_W-1:0] FIX_ONE  = 64'sd1 <<< DEF_FRAC_BITS;
   localparam logic [DATA_W-1:0]        TEN      = 64'd10 << DEF_FRAC_BITS;
   localparam logic [DATA_W-1:0]        DEF_STEP =
      ((64'd3 << DEF_FRAC_BITS) + 64'd500) / 64'd1000;
   localparam int                       HALF_RES = DEF_MAX_RESOLUTION / 2;

   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       start          = 1'b0;
   logic                       busy;
   logic signed [OFFSET_W-1:0] req_col_offset = '0;
   logic signed [OFFSET_W-1:0] req_row_offset = '0;
   logic                       rsp_valid;
   logic [ITER_W-1:0]          rsp_iteration_count;
   logic [GRAY_W-1:0]          rsp_gray_level;
   logic                       csr_write_en   = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index      = '0;
   logic [DATA_W-1:0]          csr_write_data = '0;
   int                         mismatch_count;
   int                         pending_count;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   mandelbrot_escape_time_pixel_unit DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_col_offset      (req_col_offset),
      .req_row_offset      (req_row_offset),
      .rsp_valid           (rsp_valid),
      .rsp_iteration_count (rsp_iteration_count),
      .rsp_gray_level      (rsp_gray_level),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   mandelbrot_escape_time_pixel_unit_checker pixel_check (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_col_offset      (req_col_offset),
      .req_row_offset      (req_row_offset),
      .rsp_valid           (rsp_valid),
      .rsp_iteration_count (rsp_iteration_count),
      .rsp_gray_level      (rsp_gray_level),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .mismatch_count      (mismatch_count),
      .pending_count       (pending_count)
   );

   // start stays high after acceptance so back-to-back requests need no re-raise
   task automatic send_pixel(input logic signed [OFFSET_W-1:0] col,
                             input logic signed [OFFSET_W-1:0] row);
      req_col_offset = col;
      req_row_offset = row;
      start          = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic idle_for(input int cycles);
      start = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic drain_results();
      start = 1'b0;
      @(negedge clock);
      while (pending_count != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [DATA_W-1:0] value);
      csr_index      = idx;
      csr_write_data = value;
      csr_write_en   = 1'b1;
      @(negedge clock);
      csr_write_en   = 1'b0;
   endtask

   task automatic set_view(input logic [DATA_W-1:0] re, input logic [DATA_W-1:0] im,
                           input logic [DATA_W-1:0] step, input logic [DATA_W-1:0] limit,
                           input logic [DATA_W-1:0] bound);
      drain_results();
      write_csr(CSR_CENTER_RE, re);
      write_csr(CSR_CENTER_IM, im);
      write_csr(CSR_PIXEL_STEP, step);
      write_csr(CSR_MAX_ITERATIONS, limit);
      write_csr(CSR_ESCAPE_THRESHOLD, bound);
   endtask

   // mostly inside the window, some anywhere in the field, some at the clamp bound
   function automatic logic signed [OFFSET_W-1:0] pick_offset(input int window);
      int r;
      int b;
      r = $urandom_range(0, 99);
      if (r < 10) return OFFSET_W'($urandom);
      if (r < 14) begin
         b = HALF_RES + $urandom_range(0, 1);
         return $urandom_range(0, 1) ? OFFSET_W'(b) : OFFSET_W'(-b);
      end
      return OFFSET_W'($urandom_range(0, 2 * window) - window);
   endfunction

   task automatic run_random_phase(input int items, input int idle_pct, input int window);
      for (int k = 0; k < items; k++) begin
         if ($urandom_range(1, 100) <= idle_pct) idle_for($urandom_range(1, 120));
         if (idle_pct != 0 && k % 40 == 39) drain_results();
         send_pixel(pick_offset(window), pick_offset(window));
      end
   endtask

   initial begin
      logic [DATA_W-1:0] bound;
      repeat (9) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // reset view: origin, clamped corners, near-origin cardioid point
      send_pixel(0, 0);
      send_pixel(-8192, 8191);
      send_pixel(8191, -8192);
      send_pixel(OFFSET_W'(HALF_RES), OFFSET_W'(-HALF_RES));
      send_pixel(OFFSET_W'(-HALF_RES - 1), OFFSET_W'(HALF_RES + 1));
      send_pixel(10, -20);

      // zero iteration limit
      set_view(0, 0, DEF_STEP, 0, TEN);
      send_pixel(0, 0);
      send_pixel(300, 0);

      // deepest limit, only cardioid and first-iteration escapes
      set_view(0, 0, DEF_STEP, 16'hFFFF, TEN);
      send_pixel(0, 0);
      send_pixel(8191, 0);

      // zero threshold
      set_view(0, 0, DEF_STEP, 6, 0);
      send_pixel(0, 0);
      send_pixel(-500, 0);

      // widest threshold, saturated magnitude never passes it
      set_view(0, 0, DEF_STEP, 9, SAT_MAX);
      send_pixel(-500, 0);
      send_pixel(8191, 8191);

      // extreme centers and steps
      set_view(SAT_MAX, SAT_MIN, 0, 9, TEN);
      send_pixel(123, -45);
      set_view(0, 0, SAT_MAX, 9, TEN);
      send_pixel(1, 0);
      send_pixel(-1, -1);
      send_pixel(OFFSET_W'(HALF_RES), OFFSET_W'(-HALF_RES));
      send_pixel(0, 0);
      set_view(SAT_MIN, SAT_MAX, SAT_MAX, 9, TEN);
      send_pixel(OFFSET_W'(HALF_RES), OFFSET_W'(HALF_RES));
      send_pixel(OFFSET_W'(-HALF_RES), OFFSET_W'(-HALF_RES));

      // writes to unmapped indexes leave the view alone
      drain_results();
      for (int i = CSR_ESCAPE_THRESHOLD + 1; i < 2 ** CSR_INDEX_W; i++)
         write_csr(CSR_INDEX_W'(i), {$urandom, $urandom});
      send_pixel(0, 0);

      // whole set, sender idling a third of the time
      set_view(-(FIX_ONE >>> 1), 0, DEF_STEP, 48, 64'd4 << DEF_FRAC_BITS);
      run_random_phase(167, 33, 900);

      // zoom near the cardioid / bulb neck, heavier idling
      set_view(-(FIX_ONE >>> 2) * 3, FIX_ONE >>> 3, FIX_ONE >>> 11, 80, TEN);
      run_random_phase(167, 48, 1000);

      // random views, no idling, junk in the unused register bits
      for (int v = 0; v < 4; v++) begin
         if ($urandom_range(0, 3) == 0)
            bound = {$urandom, $urandom};
         else
            bound = {1'($urandom), 63'(64'($urandom_range(1, 16)) << DEF_FRAC_BITS)};
         set_view((FIX_ONE / 1000) * $urandom_range(0, 3000) - 2 * FIX_ONE,
                  (FIX_ONE / 1000) * $urandom_range(0, 2400) - (FIX_ONE / 1000) * 1200,
                  {1'($urandom), 63'(64'($urandom_range(1, 4095)) << 36)},
                  {$urandom, 16'($urandom), 16'($urandom_range(1, 40))},
                  bound);
         run_random_phase(42, 0, 1200);
      end

      drain_results();
      repeat (3000) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("mandelbrot_escape_time_pixel_unit_test: clean");
      end else begin
         $display("mandelbrot_escape_time_pixel_unit_test: errors");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("mandelbrot_escape_time_pixel_unit_test: errors");
      $finish;
   end

endmodule
